// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros: shared assertion macros
// Concurrent property helpers on a clock with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PERW_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define PERW_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== sv/perw_pkg.sv =====
// ----------------------------------------------------------------------------
// perw_pkg: peak event rate window package
// Field widths and fixed constants shared by the rate window blocks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package perw_pkg;

  localparam int unsigned TS_W    = 48;
  localparam int unsigned PROBE_W = 24;
  localparam int unsigned CNT_W   = 10;
  localparam int unsigned SPAN_W  = 24;
  localparam int unsigned RATE_W  = 47;
  localparam int unsigned NUM_W   = 46;
  localparam int unsigned MEGA_W  = 36;

  localparam logic [CNT_W-1:0]   COUNT_MAX   = 10'd1023;
  localparam logic [MEGA_W-1:0]  Q16_MEGA    = 36'd65536000000;
  localparam logic [PROBE_W-1:0] PROBE_RESET = 24'd20000;

endpackage

// ===== sv/perw_ring.sv =====
// ----------------------------------------------------------------------------
// perw_ring: stamp ring memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module perw_ring import perw_pkg::*; #(
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [TS_W-1:0]  wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [TS_W-1:0]  rdata_o
);

  logic [TS_W-1:0] mem_q [Depth];
  logic [TS_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/perw_div.sv =====
// ----------------------------------------------------------------------------
// perw_div: rate divider
// Restoring divider, one quotient bit per cycle: count * 1e6 * 2^16 / span.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module perw_div import perw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [CNT_W-1:0]  count_i,
  input  logic [SPAN_W-1:0] span_i,
  output logic              done_o,
  output logic [NUM_W-1:0]  quot_o
);

  localparam int unsigned StepW = $clog2(NUM_W);

  logic              busy_q;
  logic              done_q;
  logic [StepW-1:0]  step_q;
  logic [NUM_W-1:0]  num_q;
  logic [SPAN_W-1:0] rem_q;
  logic [SPAN_W-1:0] den_q;
  logic [SPAN_W:0]   rem_sh;
  logic [SPAN_W:0]   trial;
  logic              fits;

  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_q};
  assign trial  = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      num_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        // quotient bits shift in from the bottom as the dividend leaves the top
        num_q  <= NUM_W'(count_i) * NUM_W'(Q16_MEGA);
        rem_q  <= '0;
        den_q  <= span_i;
        step_q <= StepW'(NUM_W - 1);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= fits ? trial[SPAN_W-1:0] : rem_sh[SPAN_W-1:0];
        num_q <= {num_q[NUM_W-2:0], fits};
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - StepW'(1);
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

// ===== sv/peak_event_rate_window_unit.sv =====
// an accepted item is read and compared against the window start, again for every stamp dropped
// from it, then goes through span, multiply and update (skipped when the window is empty or the
// probe is zero); an item marked last with a kept pair then waits on the one-bit-per-cycle rate
// divider before the result word is shown; one item is worked on at a time
// asynchronous active-low reset empties the window, clears the best pair and
// sets the probe width to 20000 us; the ring itself is not cleared
// ----------------------------------------------------------------------------
// peak_event_rate_window_unit: sliding window peak event rate
// Keeps a ring of recent stamps, finds the densest window at least half the
// probe width wide and reports its count, span and rate on the last word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module peak_event_rate_window_unit import perw_pkg::*; #(
  parameter int unsigned RING_DEPTH = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [PROBE_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [TS_W-1:0]    timestamp_us_i,
  input  logic               last_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CNT_W-1:0]   best_count_o,
  output logic [SPAN_W-1:0]  best_span_us_o,
  output logic [RATE_W-1:0]  rate_hz_q16_o,
  output logic               ring_overflow_o
);

  localparam int unsigned AW   = $clog2(RING_DEPTH);
  localparam int unsigned FW   = $clog2(RING_DEPTH + 1);
  localparam int unsigned LHSW = CNT_W + SPAN_W;
  localparam int unsigned RHSW = CNT_W + TS_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_RD2,
    ST_SPAN,
    ST_MUL,
    ST_UPD,
    ST_FIN,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e             state_q;
  logic [PROBE_W-1:0] probe_q;
  logic [TS_W-1:0]    now_q;
  logic               last_q;
  logic [AW-1:0]      head_q;
  logic [AW-1:0]      tail_q;
  logic [FW-1:0]      fill_q;
  logic [CNT_W-1:0]   kept_count_q;
  logic [SPAN_W-1:0]  kept_span_q;
  logic               ovf_q;
  logic [TS_W-1:0]    span_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               qual_q;
  logic [LHSW-1:0]    lhs_q;
  logic [RHSW-1:0]    rhs_q;
  logic [CNT_W-1:0]   best_count_q;
  logic [SPAN_W-1:0]  best_span_q;
  logic [RATE_W-1:0]  rate_q;
  logic               ovf_out_q;

  logic [TS_W-1:0]    rdata;
  logic [TS_W-1:0]    diff;
  logic               advance;
  logic               full;
  logic [AW-1:0]      tail_inc;
  logic [AW-1:0]      head_inc;
  logic [FW-1:0]      fill_m1;
  logic [CNT_W-1:0]   cnt_sat;
  logic               qual;
  logic               ring_we;
  logic               div_start;
  logic               div_done;
  logic [NUM_W-1:0]   div_quot;

  // distance from window start, modulo 2^48
  assign diff     = now_q - rdata;
  assign advance  = (fill_q != '0) && (diff > TS_W'(probe_q));
  assign full     = fill_q >= FW'(RING_DEPTH);
  assign tail_inc = (tail_q == AW'(RING_DEPTH - 1)) ? '0 : tail_q + AW'(1);
  assign head_inc = (head_q == AW'(RING_DEPTH - 1)) ? '0 : head_q + AW'(1);
  assign fill_m1  = fill_q - FW'(1);
  assign cnt_sat  = (32'(fill_m1) > 32'(COUNT_MAX)) ? COUNT_MAX : CNT_W'(fill_m1);
  assign qual     = (diff != '0) && (diff >= TS_W'(probe_q >> 1));

  assign ring_we   = (state_q == ST_CMP) && !advance;
  assign div_start = (state_q == ST_FIN) && last_q && (probe_q != '0) &&
                     (kept_count_q != '0) && (kept_span_q != '0);

  perw_ring #(
    .Depth(RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ring_we),
    .waddr_i(head_q),
    .wdata_i(now_q),
    .raddr_i(tail_q),
    .rdata_o(rdata)
  );

  perw_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .count_i(kept_count_q),
    .span_i (kept_span_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      probe_q      <= PROBE_RESET;
      now_q        <= '0;
      last_q       <= 1'b0;
      head_q       <= '0;
      tail_q       <= '0;
      fill_q       <= '0;
      kept_count_q <= '0;
      kept_span_q  <= '0;
      ovf_q        <= 1'b0;
      span_q       <= '0;
      cnt_q        <= '0;
      qual_q       <= 1'b0;
      lhs_q        <= '0;
      rhs_q        <= '0;
      best_count_q <= '0;
      best_span_q  <= '0;
      rate_q       <= '0;
      ovf_out_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        probe_q <= cfg_wdata_i;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            now_q   <= timestamp_us_i;
            last_q  <= last_item_i;
            state_q <= ST_RD;
          end
        end
        ST_RD: begin
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          if (advance) begin
            tail_q  <= tail_inc;
            fill_q  <= fill_m1;
            state_q <= ST_RD;
          end else begin
            head_q <= head_inc;
            if (full) begin
              // drop the oldest stamp, fill stays at the depth
              tail_q <= tail_inc;
              ovf_q  <= 1'b1;
            end else begin
              fill_q <= fill_q + FW'(1);
            end
            state_q <= ((probe_q != '0) && (fill_q != '0)) ? ST_RD2 : ST_FIN;
          end
        end
        ST_RD2: begin
          state_q <= ST_SPAN;
        end
        ST_SPAN: begin
          span_q  <= diff;
          cnt_q   <= cnt_sat;
          qual_q  <= qual;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          // cross products for the strictly-higher-rate test
          lhs_q   <= LHSW'(cnt_q) * LHSW'(kept_span_q);
          rhs_q   <= RHSW'(kept_count_q) * RHSW'(span_q);
          state_q <= ST_UPD;
        end
        ST_UPD: begin
          if (qual_q && ((RHSW'(lhs_q) > rhs_q) || (kept_count_q == '0))) begin
            kept_count_q <= cnt_q;
            kept_span_q  <= span_q[SPAN_W-1:0];
          end
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (!last_q) begin
            state_q <= ST_IDLE;
          end else begin
            ovf_out_q <= ovf_q;
            rate_q    <= '0;
            if (div_start) begin
              best_count_q <= kept_count_q;
              best_span_q  <= kept_span_q;
              state_q      <= ST_DIV;
            end else begin
              best_count_q <= '0;
              best_span_q  <= '0;
              state_q      <= ST_OUT;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            rate_q  <= RATE_W'(div_quot);
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_stall_i) begin
            head_q       <= '0;
            tail_q       <= '0;
            fill_q       <= '0;
            kept_count_q <= '0;
            kept_span_q  <= '0;
            ovf_q        <= 1'b0;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o      = state_q != ST_IDLE;
  assign out_valid_o     = state_q == ST_OUT;
  assign best_count_o    = best_count_q;
  assign best_span_us_o  = best_span_q;
  assign rate_hz_q16_o   = rate_q;
  assign ring_overflow_o = ovf_out_q;

endmodule

// ===== sv/perw_chk.sv =====
// ----------------------------------------------------------------------------
// perw_chk: port checker for the rate window unit
// Watches the top-level handshakes and result word over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module perw_chk import perw_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [CNT_W-1:0]  best_count_o,
  input logic [SPAN_W-1:0] best_span_us_o,
  input logic [RATE_W-1:0] rate_hz_q16_o
);

  // a stalled result word stays offered
  `PERW_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // no new word is taken while a result waits
  `PERW_ASSERT_IMPL(a_busy_on_out, clk_i, rst_ni, out_valid_o, in_stall_o)

  // an accepted word always occupies the block for the next cycle
  `PERW_ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // a rate is reported exactly when a window was kept, and no span without one
  `PERW_ASSERT_IMPL(a_rate_count, clk_i, rst_ni, out_valid_o, ((best_count_o == 0) == (rate_hz_q16_o == 0)) && ((best_count_o != 0) || (best_span_us_o == 0)))

endmodule

bind peak_event_rate_window_unit perw_chk u_perw_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .best_count_o  (best_count_o),
  .best_span_us_o(best_span_us_o),
  .rate_hz_q16_o (rate_hz_q16_o)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for peak_event_rate_window_unit
// Streams lane lists of time stamps through the block under random gaps and
// output stalls, tracks the sliding window in a local predictor and checks
// count, span, rate and the overflow flag of every result word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import perw_pkg::*;

  localparam int unsigned RING_DEPTH    = 1024;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned HOLD_AFTER    = 200;
  localparam int unsigned HOLD_CYCLES   = 3000;
  localparam int unsigned DRAIN_CYCLES  = 200;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam logic [PROBE_W-1:0] PROBE_MAX = '1;
  localparam logic [TS_W-1:0]    STAMP_MAX = '1;

  typedef struct packed {
    bit                 is_cfg;
    bit [PROBE_W-1:0]   probe;
    bit [TS_W-1:0]      stamp;
    bit                 last;
  } stamp_feed_t;

  typedef struct packed {
    bit [CNT_W-1:0]  cnt;
    bit [SPAN_W-1:0] span;
    bit [RATE_W-1:0] rate;
    bit              ovf;
  } peak_result_t;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               cfg_we_i        = 1'b0;
  logic [PROBE_W-1:0] cfg_wdata_i     = '0;
  logic               in_valid_i      = 1'b0;
  logic               in_stall_o;
  logic [TS_W-1:0]    timestamp_us_i  = '0;
  logic               last_item_i     = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i     = 1'b0;
  logic [CNT_W-1:0]   best_count_o;
  logic [SPAN_W-1:0]  best_span_us_o;
  logic [RATE_W-1:0]  rate_hz_q16_o;
  logic               ring_overflow_o;

  peak_event_rate_window_unit #(
    .RING_DEPTH(RING_DEPTH)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .timestamp_us_i  (timestamp_us_i),
    .last_item_i     (last_item_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .best_count_o    (best_count_o),
    .best_span_us_o  (best_span_us_o),
    .rate_hz_q16_o   (rate_hz_q16_o),
    .ring_overflow_o (ring_overflow_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  stamp_feed_t  stamp_feed_q[$];
  peak_result_t peak_expect_q[$];

  // window tracker
  bit [TS_W-1:0]    win_ring [RING_DEPTH];
  int unsigned      win_head, win_tail, win_fill;
  bit [CNT_W-1:0]   kept_cnt;
  bit [SPAN_W-1:0]  kept_len;
  bit               lane_ovf;
  bit [PROBE_W-1:0] probe_width = PROBE_RESET;

  bit [PROBE_W-1:0] gen_probe = PROBE_RESET;
  int unsigned      mismatch_cnt = 0;
  int unsigned      lasts_sent = 0;
  int unsigned      results_seen = 0;
  int unsigned      words_in = 0;
  int unsigned      cycle_cnt = 0;
  logic             hold_on = 1'b0;
  int unsigned      hold_cnt;
  int unsigned      tx_gap, tx_calm, cfg_settle;
  int unsigned      rx_left;
  bit               rx_stalled;

  function automatic void track_stamp(bit [TS_W-1:0] now, bit last);
    bit [TS_W-1:0] reach_us;
    bit [TS_W-1:0] probe_ext;
    int unsigned   intervals;
    bit [63:0]     quot;
    peak_result_t  res;
    probe_ext = probe_width;
    reach_us = now - win_ring[win_tail];
    while (win_fill > 0 && reach_us > probe_ext) begin
      win_tail = (win_tail + 1) % RING_DEPTH;
      win_fill--;
      reach_us = now - win_ring[win_tail];
    end
    if (win_fill >= RING_DEPTH) begin
      win_tail = (win_tail + 1) % RING_DEPTH;
      win_fill--;
      lane_ovf = 1'b1;
    end
    win_ring[win_head] = now;
    win_head = (win_head + 1) % RING_DEPTH;
    win_fill++;

    if (probe_width != 0 && win_fill >= 2) begin
      reach_us = now - win_ring[win_tail];
      intervals = win_fill - 1;
      if (intervals > COUNT_MAX) intervals = COUNT_MAX;
      if (reach_us != 0 && reach_us >= (probe_ext >> 1)) begin
        // strictly denser than the kept pair, cross-multiplied
        if (kept_cnt == 0 ||
            64'(intervals) * 64'(kept_len) > 64'(kept_cnt) * 64'(reach_us)) begin
          kept_cnt = intervals[CNT_W-1:0];
          kept_len = reach_us[SPAN_W-1:0];
        end
      end
    end

    if (last) begin
      res = '0;
      if (probe_width != 0 && kept_cnt != 0 && kept_len != 0) begin
        quot = (64'(kept_cnt) * 64'(Q16_MEGA)) / 64'(kept_len);
        res.cnt  = kept_cnt;
        res.span = kept_len;
        res.rate = quot[RATE_W-1:0];
      end
      res.ovf = lane_ovf;
      peak_expect_q = {peak_expect_q, res};
      win_head = 0;
      win_tail = 0;
      win_fill = 0;
      kept_cnt = '0;
      kept_len = '0;
      lane_ovf = 1'b0;
    end
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void note_bad(string what, logic [63:0] want, logic [63:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
  endfunction

  function automatic void add_word(bit [TS_W-1:0] stamp, bit last);
    stamp_feed_t w;
    w = '0;
    w.stamp = stamp;
    w.last = last;
    stamp_feed_q = {stamp_feed_q, w};
  endfunction

  function automatic void add_probe(bit [PROBE_W-1:0] value);
    stamp_feed_t w;
    w = '0;
    w.is_cfg = 1'b1;
    w.probe = value;
    stamp_feed_q = {stamp_feed_q, w};
    gen_probe = value;
  endfunction

  // one lane list, mostly non-decreasing with some noise mixed in
  function automatic void add_lane(int unsigned n);
    bit [TS_W-1:0] ts;
    int unsigned   step_hi;
    int unsigned   r;
    step_hi = (gen_probe == 0) ? 1000 : gen_probe / 4 + 1;
    ts = {16'($urandom), $urandom};
    if ($urandom_range(0, 9) == 0) ts = STAMP_MAX - $urandom_range(0, 4 * step_hi);
    for (int unsigned i = 0; i < n; i++) begin
      add_word(ts, i == n - 1);
      r = $urandom_range(0, 99);
      if (r < 4) ts = ts - $urandom_range(1, 4 * step_hi);
      else if (r < 8) ts = ts;
      else if (r < 12) ts = ts + gen_probe + $urandom_range(1, 1000);
      else ts = ts + $urandom_range(0, step_hi);
    end
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      timestamp_us_i <= '0;
      last_item_i    <= 1'b0;
      cfg_we_i       <= 1'b0;
      cfg_wdata_i    <= '0;
      tx_gap = 0;
      tx_calm = 0;
      cfg_settle = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        track_stamp(timestamp_us_i, last_item_i);
        if (last_item_i) lasts_sent++;
        words_in <= words_in + 1;
      end
      if (lasts_sent == results_seen) cfg_settle++;
      else cfg_settle = 0;

      if (in_valid_i && in_stall_o) begin
        cfg_we_i <= 1'b0;
      end else if (tx_gap > 0) begin
        tx_gap--;
        in_valid_i <= 1'b0;
        cfg_we_i   <= 1'b0;
      end else if (stamp_feed_q.size() == 0) begin
        in_valid_i <= 1'b0;
        cfg_we_i   <= 1'b0;
      end else if (stamp_feed_q[0].is_cfg) begin
        in_valid_i <= 1'b0;
        // probe only changes once the block has gone quiet
        if (cfg_settle >= SETTLE_CYCLES) begin
          cfg_we_i    <= 1'b1;
          cfg_wdata_i <= stamp_feed_q[0].probe;
          probe_width = stamp_feed_q[0].probe;
          void'(stamp_feed_q.pop_front());
          cfg_settle = 0;
        end else begin
          cfg_we_i <= 1'b0;
        end
      end else begin
        in_valid_i     <= 1'b1;
        timestamp_us_i <= stamp_feed_q[0].stamp;
        last_item_i    <= stamp_feed_q[0].last;
        cfg_we_i       <= 1'b0;
        void'(stamp_feed_q.pop_front());
        if (tx_calm > 0) begin
          tx_calm--;
          tx_gap = 0;
        end else begin
          tx_gap = idle_len();
          if ($urandom_range(0, 31) == 0) tx_calm = $urandom_range(16, 64);
        end
      end
    end
  end

  // long receiver hold so the block backs up into its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_on <= 1'b0;
      hold_cnt = 0;
    end else if (hold_on) begin
      hold_cnt++;
      if (hold_cnt >= HOLD_CYCLES) hold_on <= 1'b0;
    end else if (hold_cnt == 0 && words_in >= HOLD_AFTER) begin
      hold_on <= 1'b1;
    end
  end

  // monitor and receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    peak_result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_left = 0;
      rx_stalled = 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen <= results_seen + 1;
        if (peak_expect_q.size() == 0) begin
          note_bad("result word with none expected, best_count", 0, best_count_o);
        end else begin
          want = peak_expect_q.pop_front();
          if (best_count_o !== want.cnt) note_bad("best_count", want.cnt, best_count_o);
          if (best_span_us_o !== want.span) note_bad("best_span_us", want.span, best_span_us_o);
          if (rate_hz_q16_o !== want.rate) note_bad("rate_hz_q16", want.rate, rate_hz_q16_o);
          if (ring_overflow_o !== want.ovf)
            note_bad("ring_overflow", want.ovf, ring_overflow_o);
        end
      end
      if (rx_left > 0) begin
        rx_left--;
      end else if (rx_stalled) begin
        rx_stalled = 1'b0;
        rx_left = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
      end else begin
        rx_left = idle_len();
        rx_stalled = (rx_left != 0);
      end
      out_stall_i <= rx_stalled || hold_on;
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int unsigned n, filled;
    bit [PROBE_W-1:0] pick;

    // single stamp, nothing qualifies
    add_word(48'd0, 1'b1);
    // window running across the top of the stamp range
    add_word(STAMP_MAX - 48'd14999, 1'b0);
    add_word(STAMP_MAX - 48'd4999, 1'b0);
    add_word(STAMP_MAX, 1'b0);
    add_word(48'd4999, 1'b1);
    // evenly spaced, later pairs tie with the kept one
    add_word(48'd1000, 1'b0);
    add_word(48'd11000, 1'b0);
    add_word(48'd21000, 1'b0);
    add_word(48'd31000, 1'b1);
    // repeated stamp, then a stamp going backwards
    add_word(48'd50000, 1'b0);
    add_word(48'd60000, 1'b0);
    add_word(48'd60000, 1'b0);
    add_word(48'd40000, 1'b0);
    add_word(48'd45000, 1'b1);
    // probe off
    add_probe('0);
    add_word(48'd100, 1'b0);
    add_word(48'd200, 1'b0);
    add_word(48'd300, 1'b1);
    // narrowest probe
    add_probe(24'd1);
    add_word(48'd5, 1'b0);
    add_word(48'd5, 1'b0);
    add_word(48'd6, 1'b0);
    add_word(48'd7, 1'b1);
    // widest probe
    add_probe(PROBE_MAX);
    add_word(48'd0, 1'b0);
    add_word(48'(PROBE_MAX), 1'b1);

    for (int unsigned ph = 0; ph < 9; ph++) begin
      case (ph)
        0: pick = PROBE_MAX;
        1: pick = 24'd1;
        2: pick = '0;
        3: pick = PROBE_RESET;
        default: pick = (ph % 2) ? 24'($urandom_range(2, 50000)) : 24'($urandom);
      endcase
      add_probe(pick);
      filled = 0;
      while (filled < 75) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 30);
        add_lane(n);
        filled += n;
      end
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (stamp_feed_q.size() != 0 || in_valid_i || peak_expect_q.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatch_cnt == 0 && peak_expect_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
